@@ sv/iirdf1_pkg.sv @@
// Shared types, constants and codes of the direct-form-I IIR filter.
package iirdf1_pkg;

   localparam int MAX_ORDER  = 8;
   localparam int NUM_BANKS  = 4;
   localparam int TAPS       = MAX_ORDER + 1;
   localparam int FB_BASE    = NUM_BANKS * TAPS;
   localparam int COEF_DEPTH = 2 * NUM_BANKS * TAPS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int TAP_W      = $clog2(TAPS);
   localparam int STEP_W     = $clog2(2 * MAX_ORDER + 1);

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 18;
   localparam int ORDER_W    = 4;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = 42;
   localparam int FRAC_W     = 15;
   localparam int RND_W      = ACC_W - FRAC_W;
   localparam int HIST_W     = 2 * SAMPLE_W;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd2;

   localparam logic [1:0] FUNC_FILTER = 2'd0;
   localparam logic [1:0] FUNC_WR_FF  = 2'd1;
   localparam logic [1:0] FUNC_WR_FB  = 2'd2;

   localparam logic [0:0] CSR_ORDER = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
   } hist_word_type;

   typedef struct packed {
      logic             vld;
      logic             fb;
      logic [TAP_W-1:0] tap;
   } issue_tag_type;

   typedef struct packed {
      logic vld;
      logic neg;
      logic clr;
   } mac_ctl_type;

endpackage

@@ sv/iirdf1_ram.sv @@
// Generic simple dual-port RAM with registered read.
module iirdf1_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/iirdf1_mac.sv @@
// Shared multiply-accumulate unit with rounding and saturation of the sum.
module iirdf1_mac (
   input  logic                                        clock,
   input  logic                                        reset,
   input  iirdf1_pkg::mac_ctl_type                     ctl,
   input  logic signed [iirdf1_pkg::COEF_W-1:0]        coef,
   input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]      operand,
   output logic                                        busy,
   output logic signed [iirdf1_pkg::SAMPLE_W-1:0]      filtered,
   output logic                                        overflow
);

   logic signed [iirdf1_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                                 p_vld_ff;
   logic                                 p_neg_ff;
   logic signed [iirdf1_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [iirdf1_pkg::ACC_W-1:0]  term;
   logic signed [iirdf1_pkg::ACC_W-1:0]  biased;
   logic signed [iirdf1_pkg::RND_W-1:0]  rnd_val;
   logic                                 sat_hi;
   logic                                 sat_lo;

   assign prod_in = coef * operand;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= ctl.vld;
      end
      prod_ff  <= prod_in;
      p_neg_ff <= ctl.neg;
      acc_ff   <= acc_in;
   end

   always_comb begin
      term = iirdf1_pkg::ACC_W'(prod_ff);
      if (p_neg_ff) begin
         term = -term;
      end
      acc_in = acc_ff;
      if (ctl.clr) begin
         acc_in = '0;
      end else if (p_vld_ff) begin
         acc_in = acc_ff + term;
      end
   end

   assign biased  = acc_ff + iirdf1_pkg::ACC_W'(1 << (iirdf1_pkg::FRAC_W - 1));
   assign rnd_val = biased[iirdf1_pkg::ACC_W-1:iirdf1_pkg::FRAC_W];

   assign sat_hi = !rnd_val[iirdf1_pkg::RND_W-1]
                   && (|rnd_val[iirdf1_pkg::RND_W-2:iirdf1_pkg::SAMPLE_W-1]);
   assign sat_lo = rnd_val[iirdf1_pkg::RND_W-1]
                   && !(&rnd_val[iirdf1_pkg::RND_W-2:iirdf1_pkg::SAMPLE_W-1]);

   always_comb begin
      filtered = rnd_val[iirdf1_pkg::SAMPLE_W-1:0];
      if (sat_hi) begin
         filtered = {1'b0, {(iirdf1_pkg::SAMPLE_W-1){1'b1}}};
      end else if (sat_lo) begin
         filtered = {1'b1, {(iirdf1_pkg::SAMPLE_W-1){1'b0}}};
      end
   end

   assign overflow = sat_hi || sat_lo;
   assign busy     = p_vld_ff;

endmodule

@@ sv/iir_filter_direct_form_one.sv @@
// Top level of the direct-form-I IIR filter with four coefficient banks.
//
//   channel   direction   handshake               word
//   req       in          req_valid / req_stall   func, bank, coef_index, coef_value, sample
//   rsp       out         rsp_valid / rsp_stall   filtered, overflow
//   csr       in          psel/penable/pwrite     order_in_use at byte address 0
//
// A coefficient write leaves req_stall low. A sample holds req_stall high from acceptance
// until its result is rounded: one coefficient memory read per product through the
// shared multiply-accumulate, a pipeline drain and a rounding step.
// After reset a clearing pass zeroes both memories; req_stall is high then.
// A finished result waits in the output register; a later sample stalls only at its
// rounding step while that register is still full.
module iir_filter_direct_form_one (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [1:0]          req_bank,
   input  logic [3:0]          req_coef_index,
   input  logic signed [17:0]  req_coef_value,
   input  logic signed [15:0]  req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_filtered,
   output logic                rsp_overflow,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   iirdf1_pkg::state_type                 state_ff, state_in;
   logic [iirdf1_pkg::COEF_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [iirdf1_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [iirdf1_pkg::ORDER_W-1:0]        order_ff;
   logic [iirdf1_pkg::TAP_W-1:0]          ord_ff;
   logic [iirdf1_pkg::COEF_AW-1:0]        bank_base_ff;
   logic signed [iirdf1_pkg::SAMPLE_W-1:0] smp_ff;
   iirdf1_pkg::issue_tag_type             s1_ff, s1_in;
   logic                                  rsp_valid_ff;
   logic signed [iirdf1_pkg::SAMPLE_W-1:0] rsp_filtered_ff;
   logic                                  rsp_overflow_ff;

   logic                                  req_take;
   logic                                  take_sample;
   logic                                  take_coef;
   logic                                  step_last;
   logic [iirdf1_pkg::TAP_W-1:0]          tap;
   logic                                  out_free;
   logic                                  round_done;
   logic                                  csr_wr;

   logic                                  coef_wr_en;
   logic [iirdf1_pkg::COEF_AW-1:0]        coef_wr_addr;
   logic [iirdf1_pkg::COEF_W-1:0]         coef_wr_data;
   logic                                  coef_rd_en;
   logic [iirdf1_pkg::COEF_AW-1:0]        coef_rd_addr;
   logic signed [iirdf1_pkg::COEF_W-1:0]  coef_rd_data;

   logic                                  hist_wr_en;
   logic [iirdf1_pkg::TAP_W-1:0]          hist_wr_addr;
   iirdf1_pkg::hist_word_type             hist_wr_data;
   logic                                  hist_rd_en;
   logic [iirdf1_pkg::TAP_W-1:0]          hist_rd_addr;
   iirdf1_pkg::hist_word_type             hist_rd_data;

   iirdf1_pkg::mac_ctl_type               mac_ctl;
   logic signed [iirdf1_pkg::SAMPLE_W-1:0] mac_operand;
   logic                                  mac_busy;
   logic signed [iirdf1_pkg::SAMPLE_W-1:0] mac_filtered;
   logic                                  mac_overflow;

   assign req_stall   = (state_ff != iirdf1_pkg::ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign take_sample = req_take && (req_func == iirdf1_pkg::FUNC_FILTER);
   assign take_coef   = req_take
                        && (req_func == iirdf1_pkg::FUNC_WR_FF
                            || req_func == iirdf1_pkg::FUNC_WR_FB)
                        && (int'(req_bank) < iirdf1_pkg::NUM_BANKS)
                        && (int'(req_coef_index) <= iirdf1_pkg::MAX_ORDER);

   assign step_last  = (step_ff == iirdf1_pkg::STEP_W'({ord_ff, 1'b0}));
   assign tap        = ord_ff - iirdf1_pkg::TAP_W'(step_ff[iirdf1_pkg::STEP_W-1:1]);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign round_done = (state_ff == iirdf1_pkg::ST_ROUND) && out_free;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      step_in    = step_ff;
      unique case (state_ff)
         iirdf1_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == iirdf1_pkg::COEF_AW'(iirdf1_pkg::COEF_DEPTH - 1)) begin
               state_in = iirdf1_pkg::ST_IDLE;
            end
         end
         iirdf1_pkg::ST_IDLE: begin
            step_in = '0;
            if (take_sample) begin
               state_in = iirdf1_pkg::ST_RUN;
            end
         end
         iirdf1_pkg::ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_last) begin
               state_in = iirdf1_pkg::ST_DRAIN;
            end
         end
         iirdf1_pkg::ST_DRAIN: begin
            if (!s1_ff.vld && !mac_busy) begin
               state_in = iirdf1_pkg::ST_ROUND;
            end
         end
         iirdf1_pkg::ST_ROUND: begin
            if (out_free) begin
               state_in = iirdf1_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iirdf1_pkg::ST_CLEAR;
         end
      endcase
   end

   // memory ports
   always_comb begin
      coef_wr_en   = 1'b0;
      coef_wr_addr = clr_cnt_ff;
      coef_wr_data = '0;
      if (state_ff == iirdf1_pkg::ST_CLEAR) begin
         coef_wr_en = 1'b1;
      end else if (take_coef) begin
         coef_wr_en   = 1'b1;
         coef_wr_addr = iirdf1_pkg::COEF_AW'(
                           ((req_func == iirdf1_pkg::FUNC_WR_FB) ? iirdf1_pkg::FB_BASE : 0)
                           + int'(req_bank) * iirdf1_pkg::TAPS + int'(req_coef_index));
         coef_wr_data = req_coef_value;
      end

      coef_rd_en   = (state_ff == iirdf1_pkg::ST_RUN);
      coef_rd_addr = (step_ff[0] ? iirdf1_pkg::COEF_AW'(iirdf1_pkg::FB_BASE) : '0)
                     + bank_base_ff + iirdf1_pkg::COEF_AW'(tap);

      hist_rd_en   = (state_ff == iirdf1_pkg::ST_RUN) && !step_ff[0] && !step_last;
      hist_rd_addr = tap - 1'b1;

      hist_wr_en   = 1'b0;
      hist_wr_addr = s1_ff.tap;
      hist_wr_data = hist_rd_data;
      if (state_ff == iirdf1_pkg::ST_CLEAR) begin
         hist_wr_en   = (int'(clr_cnt_ff) < iirdf1_pkg::TAPS);
         hist_wr_addr = clr_cnt_ff[iirdf1_pkg::TAP_W-1:0];
         hist_wr_data = '0;
      end else if (s1_ff.vld && !s1_ff.fb && (s1_ff.tap != '0)) begin
         hist_wr_en = 1'b1;
      end else if (round_done) begin
         hist_wr_en     = 1'b1;
         hist_wr_addr   = '0;
         hist_wr_data.x = smp_ff;
         hist_wr_data.y = mac_filtered;
      end
   end

   always_comb begin
      s1_in.vld = (state_ff == iirdf1_pkg::ST_RUN);
      s1_in.fb  = step_ff[0];
      s1_in.tap = tap;

      mac_ctl.vld = s1_ff.vld;
      mac_ctl.neg = s1_ff.fb;
      mac_ctl.clr = take_sample;

      if (s1_ff.fb) begin
         mac_operand = hist_rd_data.y;
      end else if (s1_ff.tap == '0) begin
         mac_operand = smp_ff;
      end else begin
         mac_operand = hist_rd_data.x;
      end
   end

   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iirdf1_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         step_ff      <= '0;
         s1_ff.vld    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         order_ff     <= iirdf1_pkg::ORDER_RESET;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         step_ff    <= step_in;
         s1_ff.vld  <= s1_in.vld;
         if (round_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr && (paddr[2:2] == iirdf1_pkg::CSR_ORDER)) begin
            order_ff <= pwdata[iirdf1_pkg::ORDER_W-1:0];
         end
      end
      s1_ff.fb  <= s1_in.fb;
      s1_ff.tap <= s1_in.tap;
      if (take_sample) begin
         smp_ff <= req_sample;
         ord_ff <= (int'(order_ff) > iirdf1_pkg::MAX_ORDER)
                   ? iirdf1_pkg::TAP_W'(iirdf1_pkg::MAX_ORDER)
                   : iirdf1_pkg::TAP_W'(order_ff);
         bank_base_ff <= iirdf1_pkg::COEF_AW'(
                            ((int'(req_bank) < iirdf1_pkg::NUM_BANKS)
                             ? int'(req_bank) : iirdf1_pkg::NUM_BANKS - 1)
                            * iirdf1_pkg::TAPS);
      end
      if (round_done) begin
         rsp_filtered_ff <= mac_filtered;
         rsp_overflow_ff <= mac_overflow;
      end
   end

   iirdf1_ram #(
      .WIDTH (iirdf1_pkg::COEF_W),
      .DEPTH (iirdf1_pkg::COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (coef_wr_data),
      .rd_en   (coef_rd_en),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   iirdf1_ram #(
      .WIDTH (iirdf1_pkg::HIST_W),
      .DEPTH (iirdf1_pkg::TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   iirdf1_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .coef     (coef_rd_data),
      .operand  (mac_operand),
      .busy     (mac_busy),
      .filtered (mac_filtered),
      .overflow (mac_overflow)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_overflow = rsp_overflow_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2:2] == iirdf1_pkg::CSR_ORDER) ? 32'(order_ff) : '0;

endmodule

@@ sv/iirdf1_check.sv @@
// Port-level checker for the IIR filter, bound to the top level.
module iirdf1_check (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [1:0]          req_func,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [15:0]  rsp_filtered,
   input logic                rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered))
      else $error("stalled result word dropped or changed");

   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> (rsp_filtered == 16'sh7fff || rsp_filtered == 16'sh8000))
      else $error("overflow flagged on an unclamped result");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == iirdf1_pkg::FUNC_FILTER |=> req_stall)
      else $error("sample word did not occupy the filter");

   a_coef_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func != iirdf1_pkg::FUNC_FILTER |=> !req_stall)
      else $error("coefficient word stalled the input");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared without a sample in flight");

endmodule

bind iir_filter_direct_form_one iirdf1_check u_check (.*);
